@@ sv/wars_pkg.sv @@
// wars_pkg: shared widths, configuration register indexes and control structs
// for the waveform autoscale remap unit; no dependencies, compiled first
package wars_pkg;

    // frame store geometry
    localparam int SAMPLES   = 64;
    localparam int IDX_W     = $clog2(SAMPLES);

    // field widths
    localparam int DATA_W    = 16;
    localparam int CNT_W     = 16;
    localparam int REG_W     = 10;
    localparam int POS_W     = 6;
    localparam int PROD_W    = DATA_W + REG_W;

    // restoring divider: one quotient bit per step, quotient never exceeds plot_height
    localparam int DIV_STEPS = REG_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_HEIGHT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ROW    = CFG_IDX_W'(1);

    // configuration reset values
    localparam logic [REG_W-1:0] PLOT_HEIGHT_RST = REG_W'(200);
    localparam logic [REG_W-1:0] BASE_ROW_RST    = REG_W'(239);

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // take one sample into stats, and into the store while it has room
        logic rd;         // read store entry at the readout index
        logic mul;        // form (sample - min) * plot_height
        logic div;        // one divider step
        logic short_res;  // short-frame result is on the output
        logic idx_inc;    // advance readout index
        logic clear;      // frame done, back to reset statistics
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic fill;       // the next sample completes the store, or it is full already
        logic idx_last;   // readout index at the final entry
    } t_sts;

    // one result item
    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [REG_W-1:0]  row;
        logic              rows_valid;
        logic [DATA_W-1:0] frame_max;
        logic [DATA_W-1:0] frame_min;
        logic [DATA_W-1:0] frame_span;
        logic [DATA_W-1:0] latest;
        logic              run_last;
    } t_res;

endpackage

@@ sv/wars_in_if.sv @@
// wars_in_if: sample input channel, valid/ready handshake
// depends on wars_pkg for field widths
interface wars_in_if import wars_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] sample;
    logic              frame_end;

    modport source (output valid, output sample, output frame_end, input ready);
    modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

@@ sv/wars_out_if.sv @@
// wars_out_if: result output channel, valid/ready handshake
// depends on wars_pkg for field widths
interface wars_out_if import wars_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  position;
    logic [REG_W-1:0]  row;
    logic              rows_valid;
    logic [DATA_W-1:0] frame_max;
    logic [DATA_W-1:0] frame_min;
    logic [DATA_W-1:0] frame_span;
    logic [DATA_W-1:0] latest;
    logic              run_last;

    modport source (
        output valid, input ready,
        output position, output row, output rows_valid, output frame_max,
        output frame_min, output frame_span, output latest, output run_last
    );
    modport sink (
        input valid, output ready,
        input position, input row, input rows_valid, input frame_max,
        input frame_min, input frame_span, input latest, input run_last
    );
endinterface

@@ sv/wars_dp.sv @@
// wars_dp: datapath with sample store, running max/min, config registers,
// multiplier and restoring divider; depends on wars_pkg
module wars_dp import wars_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [DATA_W-1:0]    i_sample,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_res                 o_res
);

    logic [DATA_W-1:0] r_store [SAMPLES];
    logic [CNT_W-1:0]  r_count;
    logic [DATA_W-1:0] r_max;
    logic [DATA_W-1:0] r_min;
    logic [DATA_W-1:0] r_latest;
    logic [IDX_W-1:0]  r_idx;
    logic [REG_W-1:0]  r_plot_height;
    logic [REG_W-1:0]  r_base_row;
    logic [DATA_W-1:0] r_rd_data;
    logic [DATA_W-1:0] r_span;
    logic [DATA_W-1:0] r_rem;
    logic [REG_W-1:0]  r_q;

    logic              w_store_en;
    logic [DATA_W-1:0] w_diff;
    logic [PROD_W-1:0] n_prod;
    logic [DATA_W:0]   n_trial;
    logic              w_ge;
    logic [DATA_W-1:0] n_rem;
    logic [REG_W-1:0]  w_off;
    logic [REG_W-1:0]  w_row;

    // only the first SAMPLES samples of a frame land in the store
    assign w_store_en = r_count < CNT_W'(SAMPLES);

    // config registers, frame statistics and readout index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plot_height <= PLOT_HEIGHT_RST;
            r_base_row    <= BASE_ROW_RST;
            r_count       <= '0;
            r_max         <= '0;
            r_min         <= '1;
            r_idx         <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PLOT_HEIGHT: r_plot_height <= i_cfg_data;
                    CFG_BASE_ROW:    r_base_row    <= i_cfg_data;
                    default:         ;
                endcase
            end
            if (i_cmd.clear) begin
                r_count <= '0;
                r_max   <= '0;
                r_min   <= '1;
                r_idx   <= '0;
            end else begin
                if (i_cmd.accept) begin
                    if (r_count != '1) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    if (i_sample > r_max) begin
                        r_max <= i_sample;
                    end
                    if (i_sample < r_min) begin
                        r_min <= i_sample;
                    end
                end
                if (i_cmd.idx_inc) begin
                    r_idx <= r_idx + IDX_W'(1);
                end
            end
        end
    end

    // sample store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_store_en) begin
            r_store[r_count[IDX_W-1:0]] <= i_sample;
            r_latest                    <= i_sample;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_store[r_idx];
            r_span    <= r_max - r_min;
        end
    end

    // offset product, then one quotient bit per cycle
    assign w_diff  = r_rd_data - r_min;
    assign n_prod  = PROD_W'(w_diff) * PROD_W'(r_plot_height);
    assign n_trial = {r_rem, r_q[REG_W-1]};
    assign w_ge    = n_trial >= {1'b0, r_span};
    assign n_rem   = w_ge ? DATA_W'(n_trial - {1'b0, r_span}) : n_trial[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_rem <= n_prod[PROD_W-1:REG_W];
            r_q   <= n_prod[REG_W-1:0];
        end else if (i_cmd.div) begin
            r_rem <= n_rem;
            r_q   <= {r_q[REG_W-2:0], w_ge};
        end
    end

    // row from quotient, flat frame maps to base row, saturate at zero
    assign w_off = (r_span == '0) ? '0 : r_q;
    assign w_row = (w_off >= r_base_row) ? '0 : r_base_row - w_off;

    assign o_sts.fill     = r_count >= CNT_W'(SAMPLES - 1);
    assign o_sts.idx_last = r_idx == IDX_W'(SAMPLES - 1);

    // result payload
    always_comb begin
        o_res.position   = POS_W'(r_idx);
        o_res.row        = i_cmd.short_res ? '0 : w_row;
        o_res.rows_valid = !i_cmd.short_res;
        o_res.frame_max  = r_max;
        o_res.frame_min  = r_min;
        o_res.frame_span = r_max - r_min;
        o_res.latest     = r_latest;
        o_res.run_last   = i_cmd.short_res || o_sts.idx_last;
    end

endmodule

@@ sv/wars_ctrl.sv @@
// wars_ctrl: controller state machine for sample loading and frame readout
// depends on wars_pkg for command and status structs
module wars_ctrl import wars_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_frame_end,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_MUL,
        S_DIV,
        S_OUT,
        S_SHORT
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic              r_in_ready;
    logic              r_out_valid;
    logic [STEP_W-1:0] r_step;
    logic              w_accept;
    logic              w_taken;

    assign w_accept = i_in_valid && r_in_ready;
    assign w_taken  = i_out_ready && r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (w_accept && i_frame_end) begin
                    n_state = i_sts.fill ? S_READ : S_SHORT;
                end
            end
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_DIV;
            S_DIV: begin
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_taken) begin
                    n_state = i_sts.idx_last ? S_LOAD : S_READ;
                end
            end
            S_SHORT: begin
                if (w_taken) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state, handshake outputs and divider step count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_state == S_LOAD;
            r_out_valid <= (n_state == S_OUT) || (n_state == S_SHORT);
            if (r_state == S_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    // commands to the datapath
    always_comb begin
        o_cmd.accept    = w_accept;
        o_cmd.rd        = r_state == S_READ;
        o_cmd.mul       = r_state == S_MUL;
        o_cmd.div       = r_state == S_DIV;
        o_cmd.short_res = r_state == S_SHORT;
        o_cmd.idx_inc   = (r_state == S_OUT) && w_taken && !i_sts.idx_last;
        o_cmd.clear     = ((r_state == S_OUT) && w_taken && i_sts.idx_last)
                       || ((r_state == S_SHORT) && w_taken);
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

endmodule

@@ sv/waveform_autoscale_remap_unit.sv @@
// waveform_autoscale_remap_unit: top level, joins wars_ctrl and wars_dp
// depends on wars_pkg, wars_in_if, wars_out_if
// loading: one sample a cycle; ready drops after frame_end until its results are taken
// short frame: one result, valid the cycle after frame_end is accepted
// full frame: SAMPLES results, each through store read, multiply, one quotient bit
//   a cycle in the 10-step divider, and output, which waits for ready
// reset: synchronous active low; clears statistics, restores config defaults,
//   store is left as is
module waveform_autoscale_remap_unit import wars_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    wars_in_if.sink              i_in,
    wars_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    t_cmd cmd;
    t_sts sts;
    t_res res;

    // controller
    wars_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_frame_end (i_in.frame_end),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    // datapath
    wars_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_in.sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (res)
    );

    // result payload
    assign o_out.position   = res.position;
    assign o_out.row        = res.row;
    assign o_out.rows_valid = res.rows_valid;
    assign o_out.frame_max  = res.frame_max;
    assign o_out.frame_min  = res.frame_min;
    assign o_out.frame_span = res.frame_span;
    assign o_out.latest     = res.latest;
    assign o_out.run_last   = res.run_last;

`ifndef SYNTHESIS
    // no sample taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input ready while a result is pending");

    // a short-frame result is always the final one
    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.rows_valid) |-> o_out.run_last)
        else $error("short-frame result without run_last");

    // after the final result is taken the block loads again
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.run_last) |=> i_in.ready)
        else $error("not ready after final result");

    // a frame_end with an incomplete store gives a short result next cycle
    a_short_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.frame_end && !sts.fill)
        |=> (o_out.valid && !o_out.rows_valid))
        else $error("short frame did not give its result");
`endif

endmodule
